### src/addressed_crc8_frame_receiver_unit_defines.svh
// Assertion macros used by the frame core module.
`ifndef ADDRESSED_CRC8_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define ADDRESSED_CRC8_FRAME_RECEIVER_UNIT_DEFINES_SVH

// Implication in the same cycle, disabled while reset is asserted.
`define ACFR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the next cycle, disabled while reset is asserted.
`define ACFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/acfr_pkg.sv
// Package: types, constants and the CRC-8 update for the frame receiver.
package acfr_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned SETPOINT_W  = 16;
	localparam logic [7:0]  CRC_POLY    = 8'h8C;
	localparam logic [7:0]  CRC_INIT    = 8'h00;
	localparam logic [7:0]  ADDR_RESET  = 8'h01;
	localparam logic [1:0]  POS_ADDR    = 2'd0;
	localparam logic [1:0]  POS_HI      = 2'd1;
	localparam logic [1:0]  POS_LO      = 2'd2;
	localparam logic [1:0]  POS_CRC     = 2'd3;

	typedef enum logic [1:0] {
		STATUS_ACCEPTED    = 2'd0,
		STATUS_BAD_ADDRESS = 2'd1,
		STATUS_BAD_CRC     = 2'd2
	} acfr_status_t;

	// Registered byte handed from the input stage to the frame core
	typedef struct packed {
		logic             valid;
		logic [BYTE_W-1:0] data;
	} acfr_stage_t;

	// Reflected CRC-8 (Maxim), one byte, LSB first
	function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
		input logic [7:0] data_in);
		logic [7:0] crc;
		logic [7:0] d;
		logic       mix;
		crc = crc_in;
		d   = data_in;
		for (int i = 0; i < 8; i++) begin
			mix = crc[0] ^ d[0];
			crc = crc >> 1;
			if (mix) begin
				crc = crc ^ CRC_POLY;
			end
			d = d >> 1;
		end
		return crc;
	endfunction

endpackage

### src/acfr_in_stage.sv
// Input register stage: captures one received byte per transaction.
module acfr_in_stage
	import acfr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic              take,
	output acfr_stage_t       stage
);

	logic              valid_s1;
	logic [BYTE_W-1:0] rx_byte_s1;

	// Free when empty or when the core drains it this cycle
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	assign stage.valid = valid_s1;
	assign stage.data  = rx_byte_s1;

endmodule

### src/acfr_frame_core.sv
// Frame core: byte collection, CRC update, checks and result register.
`include "addressed_crc8_frame_receiver_unit_defines.svh"
module acfr_frame_core
	import acfr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [BYTE_W-1:0]     node_address,
	input  acfr_stage_t           stage,
	output logic                  take,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            frame_status,
	output logic [SETPOINT_W-1:0] held_setpoint
);

	logic [BYTE_W-1:0]     dev_addr_q;
	logic [1:0]            pos_q;
	logic [BYTE_W-1:0]     crc_q;
	logic [BYTE_W-1:0]     addr_byte_q;
	logic [BYTE_W-1:0]     hi_byte_q;
	logic [BYTE_W-1:0]     lo_byte_q;
	logic [SETPOINT_W-1:0] setpoint_q;
	logic                  out_valid_q;
	acfr_status_t          status_q;
	logic                  is_last;
	acfr_status_t          status_d;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= ADDR_RESET;
		end else if (cfg_we) begin
			dev_addr_q <= node_address;
		end
	end

	// The CRC byte may only move on when the result register is free or being drained
	assign is_last = (pos_q == POS_CRC);
	assign take    = stage.valid && (!is_last || !out_valid_q || out_ready);

	// Frame checks, address first
	always_comb begin
		if (addr_byte_q != dev_addr_q) begin
			status_d = STATUS_BAD_ADDRESS;
		end else if (crc_q != stage.data) begin
			status_d = STATUS_BAD_CRC;
		end else begin
			status_d = STATUS_ACCEPTED;
		end
	end

	// Frame position, running CRC, setpoint and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_ADDR;
			crc_q       <= CRC_INIT;
			setpoint_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result replaces the one drained in the same cycle
			if (take && is_last) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				if (is_last) begin
					pos_q <= POS_ADDR;
					crc_q <= CRC_INIT;
					if (status_d == STATUS_ACCEPTED) begin
						setpoint_q <= {hi_byte_q, lo_byte_q};
					end
				end else begin
					pos_q <= pos_q + 2'd1;
					crc_q <= crc8_update(crc_q, stage.data);
				end
			end
		end
	end

	// Payload bytes and status, no reset needed
	always_ff @(posedge clk) begin
		if (take) begin
			if (pos_q == POS_ADDR) begin
				addr_byte_q <= stage.data;
			end
			if (pos_q == POS_HI) begin
				hi_byte_q <= stage.data;
			end
			if (pos_q == POS_LO) begin
				lo_byte_q <= stage.data;
			end
			if (is_last) begin
				status_q <= status_d;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign frame_status  = status_q;
	assign held_setpoint = setpoint_q;

	// Checks
	`ACFR_ASSERT_NEXT(a_mid_frame_keeps_setpoint, clk, arst_n, take && !is_last,
		$stable(setpoint_q), "setpoint changed on a byte before the CRC byte")
	`ACFR_ASSERT_NEXT(a_crc_byte_restarts, clk, arst_n, take && is_last,
		out_valid_q && pos_q == POS_ADDR && crc_q == CRC_INIT,
		"CRC byte did not give a result and restart the frame")
	`ACFR_ASSERT_NEXT(a_position_steps, clk, arst_n, take && !is_last,
		pos_q == $past(pos_q) + 2'd1, "frame position did not advance by one")
	`ACFR_ASSERT_SAME(a_no_overwrite, clk, arst_n, out_valid_q && !out_ready,
		!(take && is_last), "pending result would be overwritten")
	`ACFR_ASSERT_SAME(a_status_code, clk, arst_n, out_valid_q,
		status_q == STATUS_ACCEPTED || status_q == STATUS_BAD_ADDRESS ||
		status_q == STATUS_BAD_CRC, "invalid status code in result")

endmodule

### src/addressed_crc8_frame_receiver_unit.sv
// Top level of the addressed CRC-8 frame receiver.
//
// Input channel: in_valid/in_ready carry rx_byte, one received byte per
// transaction. Four bytes form a frame: address, value high, value low and
// the reflected CRC-8 (0x8C, init 0) over the first three.
// Output channel: out_valid/out_ready carry one transaction per frame with
// frame_status (0 accepted, 1 address mismatch, 2 CRC mismatch) and
// held_setpoint, the last accepted 16-bit value.
// Configuration: node_address is written on a cycle with cfg_we high. The user
// must do so only while no frame is in flight; the block does not enforce this.
// Throughput is one byte per cycle while no pending result stalls it, set by
// the combinational CRC update between the input and frame state registers.
// out_valid is registered once the CRC byte moves on from the input register.
// While a result waits for out_ready, address and payload bytes of the next
// frame keep flowing; only the next CRC byte is held in the input register,
// and in_ready drops once that register is full.
// Reset clears the frame position, running CRC, setpoint and pending result
// and sets the node address to 1.
module addressed_crc8_frame_receiver_unit
	import acfr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [BYTE_W-1:0]     node_address,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [BYTE_W-1:0]     rx_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            frame_status,
	output logic [SETPOINT_W-1:0] held_setpoint
);

	acfr_stage_t stage;
	logic        take;

	acfr_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.take     (take),
		.stage    (stage)
	);

	acfr_frame_core u_frame_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.node_address  (node_address),
		.stage         (stage),
		.take          (take),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.frame_status  (frame_status),
		.held_setpoint (held_setpoint)
	);

endmodule

### sim/addressed_crc8_frame_receiver_unit_test.sv
// Testbench: frame receiver checked against a frame-level setpoint scoreboard.
`timescale 1ns / 100ps

import acfr_pkg::*;

// One frame outcome as the block should report it
typedef struct {
	acfr_status_t status;
	logic [15:0]  setpoint;
} frame_outcome_t;

// Reflected CRC-8, LSB first, one byte
function automatic logic [7:0] maxim_crc8_byte(input logic [7:0] crc, input logic [7:0] b);
	logic [7:0] c;
	logic       fb;
	c = crc;
	for (int i = 0; i < 8; i++) begin
		fb = c[0] ^ b[i];
		c  = {1'b0, c[7:1]} ^ (fb ? CRC_POLY : 8'h00);
	end
	return c;
endfunction

// Tracks frame position, CRC and setpoint; holds the outcomes still awaited
class setpoint_frame_board;
	logic [7:0]     dev_addr;
	logic [1:0]     position;
	logic [7:0]     stored [3];
	logic [7:0]     crc_acc;
	logic [15:0]    setpoint;
	frame_outcome_t awaited_outcomes [$];

	function new();
		dev_addr = ADDR_RESET;
		position = POS_ADDR;
		crc_acc  = CRC_INIT;
		setpoint = '0;
		foreach (stored[i]) stored[i] = '0;
	endfunction

	function void set_address(input logic [7:0] a);
		dev_addr = a;
	endfunction

	function int pending();
		return awaited_outcomes.size();
	endfunction

	// Accepted input byte: advance the frame and predict at the CRC byte
	function void absorb_byte(input logic [7:0] b);
		frame_outcome_t o;
		if (position != POS_CRC) begin
			stored[position] = b;
			crc_acc = maxim_crc8_byte(crc_acc, b);
			position = position + 2'd1;
		end else begin
			// address check wins when both fail
			if (stored[0] != dev_addr) begin
				o.status = STATUS_BAD_ADDRESS;
			end else if (crc_acc != b) begin
				o.status = STATUS_BAD_CRC;
			end else begin
				o.status = STATUS_ACCEPTED;
				setpoint = {stored[1], stored[2]};
			end
			o.setpoint = setpoint;
			awaited_outcomes.push_back(o);
			position = POS_ADDR;
			crc_acc  = CRC_INIT;
		end
	endfunction

	// Accepted result: empty string on match, else what differed
	function string compare_outcome(input logic [1:0] st, input logic [15:0] sp);
		frame_outcome_t o;
		string          msg;
		msg = "";
		if (awaited_outcomes.size() == 0) begin
			return $sformatf("unexpected result status=%0d setpoint=%h", st, sp);
		end
		o = awaited_outcomes.pop_front();
		if (st !== o.status) begin
			msg = $sformatf("frame_status %0d, want %0d", st, o.status);
		end
		if (sp !== o.setpoint) begin
			msg = {msg, (msg == "") ? "" : "; ",
				$sformatf("held_setpoint %h, want %h", sp, o.setpoint)};
		end
		return msg;
	endfunction
endclass

module addressed_crc8_frame_receiver_unit_test;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_we        = 1'b0;
	logic [7:0]  cfg_addr      = ADDR_RESET;
	logic        in_valid      = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte       = 8'h00;
	logic        out_valid;
	logic        out_ready     = 1'b0;
	logic [1:0]  frame_status;
	logic [15:0] held_setpoint;

	int                  errors  = 0;
	bit                  idle_on = 1'b1;
	setpoint_frame_board board   = new();

	addressed_crc8_frame_receiver_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.node_address  (cfg_addr),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.frame_status  (frame_status),
		.held_setpoint (held_setpoint)
	);

	// Clock
	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// One byte transaction with optional idle cycles in front
	task automatic send_byte(input logic [7:0] b);
		while (idle_on && $urandom_range(99) < 24) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		board.absorb_byte(b);
	endtask

	task automatic send_frame(input logic [7:0] a, input logic [7:0] h,
		input logic [7:0] l, input logic [7:0] c);
		send_byte(a);
		send_byte(h);
		send_byte(l);
		send_byte(c);
	endtask

	function automatic logic [7:0] frame_crc(input logic [7:0] a, input logic [7:0] h,
		input logic [7:0] l);
		return maxim_crc8_byte(maxim_crc8_byte(maxim_crc8_byte(CRC_INIT, a), h), l);
	endfunction

	// Address write once the block has drained
	task automatic write_address(input logic [7:0] a);
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_addr <= a;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_address(a);
	endtask

	// Mostly well-formed frames; some wrong address, wrong CRC or pure noise
	task automatic send_random_frame(input logic [7:0] a);
		logic [7:0] h, l, adr, c;
		int         kind;
		kind = $urandom_range(99);
		h    = 8'($urandom_range(255));
		l    = 8'($urandom_range(255));
		adr  = a;
		if (kind >= 65 && kind < 77) begin
			adr = a ^ 8'($urandom_range(255, 1));
		end
		c = frame_crc(adr, h, l);
		if (kind >= 77 && kind < 89) begin
			c = c ^ 8'($urandom_range(255, 1));
		end else if (kind >= 89) begin
			adr = 8'($urandom_range(255));
			c   = 8'($urandom_range(255));
		end
		send_frame(adr, h, l, c);
	endtask

	// Result side: check accepted results, stall at random while idle_on is set
	always @(posedge clk) begin : result_monitor
		string msg;
		if (arst_n && out_valid && out_ready) begin
			msg = board.compare_outcome(frame_status, held_setpoint);
			if (msg != "") begin
				report(msg);
			end
		end
		out_ready <= idle_on ? ($urandom_range(99) >= 24) : 1'b1;
	end

	// Stimulus
	initial begin
		logic [7:0] phase_addr [5];
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames at the reset address
		send_frame(8'h01, 8'h00, 8'h00, frame_crc(8'h01, 8'h00, 8'h00));
		send_frame(8'h01, 8'hFF, 8'hFF, frame_crc(8'h01, 8'hFF, 8'hFF));
		send_frame(8'h02, 8'h12, 8'h34, frame_crc(8'h02, 8'h12, 8'h34));
		send_frame(8'h01, 8'hAB, 8'hCD, ~frame_crc(8'h01, 8'hAB, 8'hCD));
		// both checks fail: address mismatch reported
		send_frame(8'h00, 8'h55, 8'hAA, frame_crc(8'h00, 8'h55, 8'hAA) ^ 8'h01);
		write_address(8'hFF);
		send_frame(8'hFF, 8'h80, 8'h01, frame_crc(8'hFF, 8'h80, 8'h01));

		// random phases under several addresses; third phase runs without idling
		phase_addr[0] = 8'h00;
		phase_addr[1] = 8'($urandom_range(255));
		phase_addr[2] = 8'hFF;
		phase_addr[3] = 8'($urandom_range(255));
		phase_addr[4] = ADDR_RESET;
		for (int p = 0; p < 5; p++) begin
			write_address(phase_addr[p]);
			idle_on = (p != 2);
			repeat (40) send_random_frame(phase_addr[p]);
		end
		idle_on = 1'b1;

		// drain
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Run limit
	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

### sim.f
+incdir+src
src/acfr_pkg.sv
src/acfr_in_stage.sv
src/acfr_frame_core.sv
src/addressed_crc8_frame_receiver_unit.sv
sim/addressed_crc8_frame_receiver_unit_test.sv
